// ===== rtl/slcm_pkg.sv =====
// ----------------------------------------------------------------------------
// slcm_pkg
// Shared types and constants of the sticky least-loaded core map: field
// widths, command and status codes, register indexes and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package slcm_pkg;

   // Defaults of the top-level parameters
   localparam int DEF_TABLE_DEPTH = 256;
   localparam int DEF_MAX_CORES   = 16;
   localparam int DEF_KEY_WIDTH   = 48;

   // Request and response field widths
   localparam int GROUP_KEY_W = 48;
   localparam int CORE_W      = 4;
   localparam int STATUS_W    = 3;

   // Per-core load counters
   localparam int                LOAD_W   = 9;
   localparam logic [LOAD_W-1:0] LOAD_MAX = 9'd511;

   // Configuration register file
   localparam int                  ACTIVE_W     = 5;
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd1;
   localparam int                  CSR_AW       = 3;
   localparam int                  CSR_DW       = 32;
   localparam int                  CSR_IDX_W    = 1;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_CORES = 1'b0;

   // Request commands
   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK             = 3'd0,
      ST_MISMATCH       = 3'd1,
      ST_REMOVE_MISSING = 3'd2,
      ST_FULL           = 3'd3,
      ST_BAD_CORE       = 3'd4
   } status_type;

   // Controller to datapath
   typedef struct packed {
      logic ready;
      logic accept;
      logic clear_step;
      logic scan_step;
      logic decide;
      logic min_step;
      logic load_read;
      logic load_write;
      logic resp_load;
   } slcm_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_valid;
      logic clear_done;
      logic scan_done;
      logic min_done;
      logic is_remove;
      logic found;
      logic bad_core;
      logic full;
      logic exp_valid;
      logic rsp_free;
   } slcm_stat_type;

endpackage

// ===== rtl/slcm_if.sv =====
// ----------------------------------------------------------------------------
// slcm_if
// Request and response channels of the core map: valid/ready handshake plus
// payload, with source and sink views.
// ----------------------------------------------------------------------------
interface slcm_req_if import slcm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   cmd;
   logic [GROUP_KEY_W-1:0] group_key;
   logic                   expected_valid;
   logic [CORE_W-1:0]      expected_core;

   modport source (output valid, cmd, group_key, expected_valid, expected_core,
                   input ready);
   modport sink   (input valid, cmd, group_key, expected_valid, expected_core,
                   output ready);
endinterface

interface slcm_rsp_if import slcm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CORE_W-1:0]   core;
   logic [STATUS_W-1:0] status;
   logic                newly_mapped;

   modport source (output valid, core, status, newly_mapped, input ready);
   modport sink   (input valid, core, status, newly_mapped, output ready);
endinterface

// ===== rtl/slcm_ram.sv =====
// ----------------------------------------------------------------------------
// slcm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/slcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// slcm_ctrl
// Sequencer of the core map: clearing pass, table scan, decision, least-load
// search, load counter update and response hand-off.
// ----------------------------------------------------------------------------
module slcm_ctrl import slcm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  slcm_stat_type stat_in,
   output slcm_cmd_type  cmd_out
);

   typedef enum logic [7:0] {
      S_CLEAR   = 8'b0000_0001,
      S_IDLE    = 8'b0000_0010,
      S_SCAN    = 8'b0000_0100,
      S_DECIDE  = 8'b0000_1000,
      S_MIN     = 8'b0001_0000,
      S_LOAD_RD = 8'b0010_0000,
      S_LOAD_WR = 8'b0100_0000,
      S_RESP    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd_out  = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd_out.clear_step = 1'b1;
            if (stat_in.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd_out.ready = 1'b1;
            if (stat_in.req_valid) begin
               cmd_out.accept = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd_out.scan_step = 1'b1;
            if (stat_in.scan_done) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd_out.decide = 1'b1;
            if (stat_in.is_remove) begin
               state_in = stat_in.found ? S_LOAD_RD : S_RESP;
            end else if (stat_in.found || stat_in.bad_core || stat_in.full) begin
               state_in = S_RESP;
            end else if (stat_in.exp_valid) begin
               state_in = S_LOAD_RD;
            end else begin
               state_in = S_MIN;
            end
         end
         S_MIN: begin
            cmd_out.min_step = 1'b1;
            if (stat_in.min_done) state_in = S_LOAD_RD;
         end
         S_LOAD_RD: begin
            cmd_out.load_read = 1'b1;
            state_in          = S_LOAD_WR;
         end
         S_LOAD_WR: begin
            cmd_out.load_write = 1'b1;
            state_in           = S_RESP;
         end
         S_RESP: begin
            if (stat_in.rsp_free) begin
               cmd_out.resp_load = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/slcm_datapath.sv =====
// ----------------------------------------------------------------------------
// slcm_datapath
// Request latch, map table and load counter memories, scan and minimum
// search pipelines, result and response registers.
// ----------------------------------------------------------------------------
module slcm_datapath import slcm_pkg::*; #(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int MAX_CORES   = DEF_MAX_CORES,
   parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   slcm_req_if.sink            req_if,
   slcm_rsp_if.source          rsp_if,
   input  logic [ACTIVE_W-1:0] active_cores,
   input  slcm_cmd_type        cmd_in,
   output slcm_stat_type       stat_out
);

   localparam int KW        = (KEY_WIDTH < GROUP_KEY_W) ? KEY_WIDTH : GROUP_KEY_W;
   localparam int TW        = $clog2(TABLE_DEPTH);
   localparam int CW        = $clog2(MAX_CORES);
   localparam int NW        = $clog2(MAX_CORES + 1);
   localparam int CXW       = (CW > CORE_W) ? CW : CORE_W;
   localparam int ENTRY_W   = 1 + CW + KW;
   localparam int CLEAR_LEN = (TABLE_DEPTH > MAX_CORES) ? TABLE_DEPTH : MAX_CORES;
   localparam int CLW       = $clog2(CLEAR_LEN);

   function automatic logic [CORE_W-1:0] core_field(input logic [CW-1:0] c);
      logic [CXW-1:0] wide;
      wide = CXW'(c);
      return wide[CORE_W-1:0];
   endfunction

   // Latched request
   logic              req_cmd_ff;
   logic [KW-1:0]     req_key_ff;
   logic              req_exp_valid_ff;
   logic [CORE_W-1:0] req_exp_core_ff;

   // Clearing pass and scan state
   logic [CLW-1:0] clr_cnt_ff, clr_cnt_in;
   logic [TW:0]    scan_addr_ff, scan_addr_in;
   logic           tbl_vld_ff, tbl_vld_in;
   logic [TW-1:0]  tbl_idx_ff;
   logic           found_ff, found_in;
   logic [TW-1:0]  found_idx_ff;
   logic [CW-1:0]  found_core_ff;
   logic           free_ff, free_in;
   logic [TW-1:0]  free_idx_ff;

   // Minimum search state
   logic [NW-1:0]     min_cnt_ff, min_cnt_in;
   logic              ld_vld_ff, ld_vld_in;
   logic [CW-1:0]     ld_idx_ff;
   logic [LOAD_W-1:0] best_load_ff;
   logic [CW-1:0]     best_idx_ff;
   logic [CW-1:0]     target_ff;

   // Result and response
   logic [CORE_W-1:0] res_core_ff;
   status_type        res_status_ff;
   logic              res_new_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CORE_W-1:0] rsp_core_ff;
   status_type        rsp_status_ff;
   logic              rsp_new_ff;

   // Memory ports
   logic               tbl_we, tbl_re;
   logic [TW-1:0]      tbl_waddr;
   logic [ENTRY_W-1:0] tbl_wdata, tbl_rdata;
   logic               ld_we, ld_re;
   logic [CW-1:0]      ld_waddr, ld_raddr;
   logic [LOAD_W-1:0]  ld_wdata, ld_rdata;

   logic              e_valid;
   logic [CW-1:0]     e_core;
   logic [KW-1:0]     e_key;
   logic              key_hit;
   logic [31:0]       act32, n32;
   logic              bad_core, mismatch, is_remove;
   logic              clr_tbl, clr_ld, tbl_issue, ld_issue;
   logic              best_take;
   logic [LOAD_W-1:0] best_load_nx;
   logic [CW-1:0]     best_idx_nx;
   logic              min_done;

   // Effective active core count: zero acts as one, clamp to MAX_CORES
   assign act32 = 32'(active_cores);
   assign n32   = (act32 == 32'd0) ? 32'd1 :
                  ((act32 > 32'(MAX_CORES)) ? 32'(MAX_CORES) : act32);

   assign is_remove = (req_cmd_ff == CMD_REMOVE);
   assign bad_core  = req_exp_valid_ff && (32'(req_exp_core_ff) >= n32);
   assign mismatch  = req_exp_valid_ff && (CXW'(req_exp_core_ff) != CXW'(found_core_ff));

   assign e_valid = tbl_rdata[ENTRY_W-1];
   assign e_core  = tbl_rdata[KW +: CW];
   assign e_key   = tbl_rdata[KW-1:0];
   assign key_hit = e_valid && (e_key == req_key_ff);

   assign clr_tbl   = cmd_in.clear_step && (32'(clr_cnt_ff) < 32'(TABLE_DEPTH));
   assign clr_ld    = cmd_in.clear_step && (32'(clr_cnt_ff) < 32'(MAX_CORES));
   assign tbl_issue = cmd_in.scan_step && (32'(scan_addr_ff) < 32'(TABLE_DEPTH));
   assign ld_issue  = cmd_in.min_step && (32'(min_cnt_ff) < n32);

   assign best_take    = ld_vld_ff && ((ld_idx_ff == '0) || (ld_rdata < best_load_ff));
   assign best_load_nx = best_take ? ld_rdata : best_load_ff;
   assign best_idx_nx  = best_take ? ld_idx_ff : best_idx_ff;
   assign min_done     = ld_vld_ff && (32'(ld_idx_ff) == (n32 - 32'd1));

   // Memory port selection
   always_comb begin
      tbl_we    = 1'b0;
      tbl_waddr = clr_cnt_ff[TW-1:0];
      tbl_wdata = '0;
      ld_we     = 1'b0;
      ld_waddr  = clr_cnt_ff[CW-1:0];
      ld_wdata  = '0;
      if (clr_tbl) tbl_we = 1'b1;
      if (clr_ld)  ld_we  = 1'b1;
      if (cmd_in.load_write) begin
         tbl_we   = 1'b1;
         ld_we    = 1'b1;
         ld_waddr = target_ff;
         if (is_remove) begin
            tbl_waddr = found_idx_ff;
            tbl_wdata = '0;
            ld_wdata  = (ld_rdata != '0) ? (ld_rdata - LOAD_W'(1)) : ld_rdata;
         end else begin
            tbl_waddr = free_idx_ff;
            tbl_wdata = {1'b1, target_ff, req_key_ff};
            ld_wdata  = (ld_rdata < LOAD_MAX) ? (ld_rdata + LOAD_W'(1)) : ld_rdata;
         end
      end
   end

   assign tbl_re   = tbl_issue;
   assign ld_re    = ld_issue || cmd_in.load_read;
   assign ld_raddr = cmd_in.load_read ? target_ff : min_cnt_ff[CW-1:0];

   slcm_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_en   (tbl_re),
      .rd_addr (scan_addr_ff[TW-1:0]),
      .rd_data (tbl_rdata)
   );

   slcm_ram #(.WIDTH(LOAD_W), .DEPTH(MAX_CORES)) u_load (
      .clock   (clock),
      .wr_en   (ld_we),
      .wr_addr (ld_waddr),
      .wr_data (ld_wdata),
      .rd_en   (ld_re),
      .rd_addr (ld_raddr),
      .rd_data (ld_rdata)
   );

   // Control next values
   always_comb begin
      clr_cnt_in   = cmd_in.clear_step ? (clr_cnt_ff + CLW'(1)) : clr_cnt_ff;
      scan_addr_in = tbl_issue ? (scan_addr_ff + (TW+1)'(1)) : scan_addr_ff;
      tbl_vld_in   = tbl_issue;
      found_in     = found_ff || (tbl_vld_ff && key_hit);
      free_in      = free_ff || (tbl_vld_ff && !e_valid);
      min_cnt_in   = ld_issue ? (min_cnt_ff + NW'(1)) : min_cnt_ff;
      ld_vld_in    = ld_issue;
      if (cmd_in.accept) begin
         scan_addr_in = '0;
         found_in     = 1'b0;
         free_in      = 1'b0;
      end
      if (cmd_in.decide) begin
         min_cnt_in = '0;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (cmd_in.resp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         scan_addr_ff <= '0;
         tbl_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         min_cnt_ff   <= '0;
         ld_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_cnt_ff   <= clr_cnt_in;
         scan_addr_ff <= scan_addr_in;
         tbl_vld_ff   <= tbl_vld_in;
         found_ff     <= found_in;
         free_ff      <= free_in;
         min_cnt_ff   <= min_cnt_in;
         ld_vld_ff    <= ld_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd_in.accept) begin
         req_cmd_ff       <= req_if.cmd;
         req_key_ff       <= req_if.group_key[KW-1:0];
         req_exp_valid_ff <= req_if.expected_valid;
         req_exp_core_ff  <= req_if.expected_core;
      end
      tbl_idx_ff <= scan_addr_ff[TW-1:0];
      if (tbl_vld_ff && key_hit && !found_ff) begin
         found_idx_ff  <= tbl_idx_ff;
         found_core_ff <= e_core;
      end
      if (tbl_vld_ff && !e_valid && !free_ff) begin
         free_idx_ff <= tbl_idx_ff;
      end
      ld_idx_ff    <= min_cnt_ff[CW-1:0];
      best_load_ff <= best_load_nx;
      best_idx_ff  <= best_idx_nx;
      if (cmd_in.decide) begin
         target_ff <= is_remove ? found_core_ff : CW'(req_exp_core_ff);
         if (is_remove) begin
            res_core_ff <= '0;
            res_new_ff  <= 1'b0;
            if (found_ff) res_status_ff <= ST_OK;
            else res_status_ff <= ST_REMOVE_MISSING;
         end else if (found_ff) begin
            res_new_ff <= 1'b0;
            if (mismatch) begin
               res_core_ff   <= '0;
               res_status_ff <= ST_MISMATCH;
            end else begin
               res_core_ff   <= core_field(found_core_ff);
               res_status_ff <= ST_OK;
            end
         end else if (bad_core) begin
            res_core_ff   <= '0;
            res_status_ff <= ST_BAD_CORE;
            res_new_ff    <= 1'b0;
         end else if (!free_ff) begin
            res_core_ff   <= '0;
            res_status_ff <= ST_FULL;
            res_new_ff    <= 1'b0;
         end else begin
            res_core_ff   <= '0;
            res_status_ff <= ST_OK;
            res_new_ff    <= 1'b1;
         end
      end
      // Take the winner, including the last compare of the search
      if (cmd_in.min_step && min_done) begin
         target_ff <= best_idx_nx;
      end
      if (cmd_in.load_write && !is_remove) begin
         res_core_ff <= core_field(target_ff);
      end
      if (cmd_in.resp_load) begin
         rsp_core_ff   <= res_core_ff;
         rsp_status_ff <= res_status_ff;
         rsp_new_ff    <= res_new_ff;
      end
   end

   assign req_if.ready        = cmd_in.ready;
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.core         = rsp_core_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.newly_mapped = rsp_new_ff;

   always_comb begin
      stat_out            = '0;
      stat_out.req_valid  = req_if.valid;
      stat_out.clear_done = (32'(clr_cnt_ff) == 32'(CLEAR_LEN - 1));
      stat_out.scan_done  = tbl_vld_ff && (32'(tbl_idx_ff) == 32'(TABLE_DEPTH - 1));
      stat_out.min_done   = min_done;
      stat_out.is_remove  = is_remove;
      stat_out.found      = found_ff;
      stat_out.bad_core   = bad_core;
      stat_out.full       = !free_ff;
      stat_out.exp_valid  = req_exp_valid_ff;
      stat_out.rsp_free   = !rsp_valid_ff || rsp_if.ready;
   end

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd_in.resp_load |-> (!rsp_valid_ff || rsp_if.ready))
      else $error("response register overwritten while held");

   a_new_is_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_new_ff) |-> (rsp_status_ff == ST_OK))
      else $error("new mapping reported with error status");

   a_scan_pipe: assert property (@(posedge clock) disable iff (reset)
      tbl_vld_ff |-> $past(cmd_in.scan_step))
      else $error("table read data valid outside scan");

   a_target_range: assert property (@(posedge clock) disable iff (reset)
      (cmd_in.load_write && !is_remove) |-> (32'(target_ff) < n32))
      else $error("new mapping targets inactive core");

endmodule

// ===== rtl/sticky_least_loaded_core_map.sv =====
// ----------------------------------------------------------------------------
// sticky_least_loaded_core_map
// Sticky key-to-core map with least-loaded placement of new keys.
// ----------------------------------------------------------------------------
// The block maps group keys to cores and keeps a count of mapped keys per
// core. A lookup request returns the stored core of a known key (or flags a
// mismatch against a requested core); an unknown key is placed on the
// requested core, or on the least-loaded active core with ties to the lowest
// number, and takes the lowest free table slot. A remove request deletes the
// entry and lowers its core's count. One request is handled at a time: each
// one scans the whole table through the single read port of the table RAM,
// one entry a cycle. A request only reads the table on a hit, a mismatch or
// any error, and also updates an entry and a load counter otherwise; a new
// key with no requested core first runs the least-load search over the
// first n counters of the load counter RAM, where n is the effective active
// core count (zero counts as one, values above MAX_CORES as MAX_CORES). The
// response sits in an output register, so the next request is taken while
// it waits; that request stalls only at its own hand-off if the earlier
// response is still held. After reset the block runs a clearing pass of the
// table and the load counters with req_if.ready low; configuration writes
// are taken at any time. active_cores lives at byte address 0 of the APB
// port; write it only while no request is in flight.
// ----------------------------------------------------------------------------
module sticky_least_loaded_core_map import slcm_pkg::*; #(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int MAX_CORES   = DEF_MAX_CORES,
   parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   slcm_req_if.sink          req_if,
   slcm_rsp_if.source        rsp_if,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   logic [ACTIVE_W-1:0]  active_ff, active_in;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic                 csr_write;
   slcm_cmd_type         cmd;
   slcm_stat_type        stat;

   // Register index is the word address; byte offset is ignored
   assign csr_idx   = paddr[CSR_AW-1:2];
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   // Hold the active core count; keep only its five low bits on a write
   always_comb begin
      active_in = active_ff;
      if (csr_write && (csr_idx == REG_ACTIVE_CORES)) begin
         active_in = pwdata[ACTIVE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else begin
         active_ff <= active_in;
      end
   end

   // Return the raw register; clamping to the valid range happens at use
   assign prdata = (csr_idx == REG_ACTIVE_CORES) ? CSR_DW'(active_ff) : '0;

   // Sequencer: clear, scan, decide, search, update, respond
   slcm_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .stat_in (stat),
      .cmd_out (cmd)
   );

   // Table, load counters and result registers
   slcm_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .MAX_CORES   (MAX_CORES),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_if       (req_if),
      .rsp_if       (rsp_if),
      .active_cores (active_ff),
      .cmd_in       (cmd),
      .stat_out     (stat)
   );

endmodule
